// File: sv/voice_channel_allocator_top_assert.svh
// Assertion macros for the voice channel allocator
`ifndef VOICE_CHANNEL_ALLOCATOR_TOP_ASSERT_SVH
`define VOICE_CHANNEL_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define VCA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define VCA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/vca_pkg.sv
package vca_pkg;

    localparam int ORIGIN_BITS      = 16;
    localparam int SOUND_BITS       = 10;
    localparam int PRIO_BITS        = 8;
    localparam int CHAN_BITS        = 5;
    localparam int FUNC_BITS        = 3;
    localparam int CFG_BITS         = 6;
    localparam int NUM_CHANNELS_DEF = 32;

    localparam logic [CFG_BITS-1:0] ACTIVE_RESET = CFG_BITS'(32);

    typedef enum logic [FUNC_BITS-1:0] {
        FN_ALLOC       = 3'd0,
        FN_STOP_ORIGIN = 3'd1,
        FN_QUERY       = 3'd2,
        FN_STOP_ALL    = 3'd3,
        FN_RELEASE     = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [FUNC_BITS-1:0]   func;
        logic [ORIGIN_BITS-1:0] origin_id;
        logic [SOUND_BITS-1:0]  sound_id;
        logic [PRIO_BITS-1:0]   priority_req;
        logic                   singular;
        logic                   multiple;
        logic                   flags_is_one;
        logic [CHAN_BITS-1:0]   channel;
    } t_req;

    typedef struct packed {
        logic                 ok;
        logic [CHAN_BITS-1:0] channel_index;
        logic                 stopped_previous;
    } t_rsp;

    typedef struct packed {
        logic [ORIGIN_BITS-1:0] origin;
        logic [SOUND_BITS-1:0]  sound;
        logic [PRIO_BITS-1:0]   prio;
        logic                   flags_one;
    } t_entry;

endpackage

// File: sv/vca_chan_ram.sv
module vca_chan_ram
    import vca_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [CW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic [CW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [NUM_CHANNELS];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: sv/voice_channel_allocator_top.sv
// Stop all, release, refusals and unused codes strobe the result in the cycle after the
// accepting edge; a scan walks the active channels, and an allocate that falls through to
// the priority pass scans them again. One channel is compared per cycle by the single
// match unit on the registered table read port; busy stays high through the result strobe,
// so the next word is accepted in the cycle after it, not before; no receiver stall.
// Synchronous active-low reset frees every channel and sets the active channel count to 32.
`include "voice_channel_allocator_top_assert.svh"

module voice_channel_allocator_top
    import vca_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  t_req                i_req,
    output logic                o_done,
    output t_rsp                o_result,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CFG_BITS-1:0] i_cfg_data
);

    localparam int CW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int CNT_W = $clog2(NUM_CHANNELS + 1);

    t_state                  r_state, n_state;
    t_req                    r_req;
    logic [CFG_BITS-1:0]     r_active;
    logic [NUM_CHANNELS-1:0] r_valid;
    logic [CNT_W-1:0]        r_live;
    logic [CNT_W-1:0]        r_addr;
    logic                    r_pend;
    logic                    r_pass;
    logic [CW-1:0]           r_cidx;
    logic                    r_ok;
    logic [CW-1:0]           r_idx;
    logic                    r_stop;

    logic [CNT_W-1:0] n_chan;
    t_entry           rd_entry;
    t_entry           wr_entry;
    logic             ram_we;
    logic             cur_v;
    logic             hit;
    logic             hit_stop;
    logic             scan_end;
    logic             scan_op;
    logic             rel_ok;
    logic             is_alloc;

    assign n_chan = (32'(r_active) < NUM_CHANNELS) ? CNT_W'(r_active) : CNT_W'(NUM_CHANNELS);

    assign is_alloc = (r_req.func == FN_ALLOC);
    assign cur_v    = r_valid[r_cidx];
    assign scan_end = !r_pend && (r_addr >= n_chan);

    assign scan_op = ((i_req.func == FN_ALLOC) && (i_req.sound_id != '0))
                  || ((i_req.func == FN_STOP_ORIGIN) && (i_req.origin_id != '0))
                  || (i_req.func == FN_QUERY);

    assign rel_ok = (32'(i_req.channel) < 32'(n_chan)) && r_valid[CW'(i_req.channel)];

    always_comb begin
        hit      = 1'b0;
        hit_stop = 1'b0;
        if (r_pend) begin
            priority if (is_alloc) begin
                if (!r_pass) begin
                    if (!cur_v) begin
                        hit = 1'b1;
                    end else if (!r_req.multiple &&
                                 ((r_req.singular && rd_entry.sound == r_req.sound_id) ||
                                  (r_req.origin_id != '0 && rd_entry.origin == r_req.origin_id &&
                                   (rd_entry.sound == r_req.sound_id ||
                                    (rd_entry.flags_one && r_req.flags_is_one))))) begin
                        hit      = 1'b1;
                        hit_stop = 1'b1;
                    end
                end else if (cur_v && rd_entry.prio >= r_req.priority_req) begin
                    hit      = 1'b1;
                    hit_stop = 1'b1;
                end
            end else if (r_req.func == FN_STOP_ORIGIN) begin
                hit = cur_v && (rd_entry.origin == r_req.origin_id);
            end else if (r_req.func == FN_QUERY) begin
                hit = cur_v &&
                      ((r_req.origin_id != '0 && rd_entry.origin == r_req.origin_id) ||
                       (r_req.sound_id != '0 && rd_entry.sound == r_req.sound_id));
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = scan_op ? ST_SCAN : ST_RESP;
                end
            end
            ST_SCAN: begin
                if (hit || (scan_end && !(is_alloc && !r_pass))) begin
                    n_state = ST_RESP;
                end
            end
            ST_RESP: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        busy        = (r_state != ST_IDLE);
        o_cfg_ready = (r_state == ST_IDLE);
        o_done      = (r_state == ST_RESP);
        o_result.ok               = r_ok;
        o_result.channel_index    = CHAN_BITS'(r_idx);
        o_result.stopped_previous = r_stop;
        ram_we      = (r_state == ST_RESP) && is_alloc && r_ok;
    end

    assign wr_entry.origin    = r_req.origin_id;
    assign wr_entry.sound     = r_req.sound_id;
    assign wr_entry.prio      = r_req.priority_req;
    assign wr_entry.flags_one = r_req.flags_is_one;

    vca_chan_ram #(
        .NUM_CHANNELS(NUM_CHANNELS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_idx),
        .i_wdata(wr_entry),
        .i_raddr(r_addr[CW-1:0]),
        .o_rdata(rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_active <= ACTIVE_RESET;
            r_valid  <= '0;
            r_live   <= '0;
            r_pend   <= 1'b0;
            r_pass   <= 1'b0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_cfg_valid) begin
                        r_active <= i_cfg_data;
                        r_valid  <= '0;
                        r_live   <= '0;
                    end
                    r_pend <= 1'b0;
                    r_pass <= 1'b0;
                end
                ST_SCAN: begin
                    if (hit) begin
                        r_pend <= 1'b0;
                    end else if (scan_end && is_alloc && !r_pass) begin
                        r_pass <= 1'b1;
                        r_pend <= 1'b0;
                    end else begin
                        r_pend <= (r_addr < n_chan);
                    end
                end
                ST_RESP: begin
                    if (r_req.func == FN_STOP_ALL) begin
                        r_valid <= '0;
                        r_live  <= '0;
                    end else if (r_ok && is_alloc) begin
                        r_valid[r_idx] <= 1'b1;
                        if (!r_stop) begin
                            r_live <= r_live + CNT_W'(1);
                        end
                    end else if (r_ok && (r_req.func == FN_STOP_ORIGIN ||
                                          r_req.func == FN_RELEASE)) begin
                        r_valid[r_idx] <= 1'b0;
                        r_live         <= r_live - CNT_W'(1);
                    end
                end
                default: r_pend <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_cidx <= r_addr[CW-1:0];
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    r_req  <= i_req;
                    r_addr <= '0;
                    r_ok   <= 1'b0;
                    r_idx  <= '0;
                    r_stop <= 1'b0;
                    if (i_req.func == FN_STOP_ALL) begin
                        r_ok <= (r_live != '0);
                    end else if (i_req.func == FN_RELEASE && rel_ok) begin
                        r_ok  <= 1'b1;
                        r_idx <= CW'(i_req.channel);
                    end
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    r_ok   <= 1'b1;
                    r_idx  <= r_cidx;
                    r_stop <= hit_stop;
                end else if (scan_end && is_alloc && !r_pass) begin
                    r_addr <= '0;
                end else if (r_addr < n_chan) begin
                    r_addr <= r_addr + CNT_W'(1);
                end
            end
            ST_RESP: begin
            end
            default: begin
            end
        endcase
    end

    `VCA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `VCA_ASSERT_NEXT(a_done_pulse, o_done, !o_done && !busy, "result strobe not a single cycle")
    `VCA_ASSERT_NOW(a_refuse_zero, o_done && !o_result.ok,
        o_result.channel_index == '0 && !o_result.stopped_previous, "refusal with nonzero fields")
    `VCA_ASSERT_NOW(a_live_count, 1'b1, $countones(r_valid) == 32'(r_live),
        "live channel count out of step with valid bits")

endmodule
